// ----- rtl/core/hksm_pkg.sv -----
// shared types, constants and hash function for the key to slot map
package hksm_pkg;

  localparam int CAPACITY_DEF = 4096;
  localparam int BUCKETS_DEF  = 1024;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CSTART = 2'd2;
  localparam logic [1:0] OP_CNEXT  = 2'd3;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CSTART   = 3'd4;
  localparam logic [2:0] ST_CITEM    = 3'd5;
  localparam logic [2:0] ST_CEND     = 3'd6;

  localparam logic [31:0] HASH_LO_MASK = 32'h0000ffff;
  localparam logic [31:0] HASH_MID_MASK = 32'h00ff0000;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
  } hksm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot;
    logic [31:0] key_out;
    logic [12:0] item_count;
  } hksm_out_t;

  // folds the key before the multiply
  function automatic logic [31:0] hash_fold(input logic [31:0] key);
    hash_fold = (key & HASH_LO_MASK) ^ ((key & HASH_MID_MASK) >> 8) ^ (key >> 24);
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic cap_req;     // capture request, start hash
    logic hash_mix;    // finish hash after multiply
    logic head_take;   // take head as walk pointer
    logic step;        // advance walk pointer along chain
    logic do_insert;   // write new entry and bucket head
    logic do_cstart;
    logic key_rd_cur;  // read key at cursor
    logic emit;        // load result register
    logic [2:0] st;    // status to report
    logic use_walk;    // slot from walk pointer
    logic use_cur;     // slot and key from cursor
    logic use_new;     // slot from entry count
    logic clr_sweep;   // clearing pass write
  } hksm_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic walk_ok;      // walk pointer valid and below count
    logic key_hit;
    logic room;         // count below effective maximum
    logic cur_ok;       // cursor below limit
    logic sweep_done;
  } hksm_sts_t;

endpackage

// ----- rtl/core/hashed_key_to_slot_map_unit.sv -----
// top level of the hashed key to slot map
// Keys hash into buckets whose chains live in block ram. After reset a clearing
// pass writes every bucket head with busy high. A lookup or insert folds and
// multiplies the key, mixes it into a bucket, reads the bucket head and then
// walks the chain, each step waiting on the registered reads of the head, key
// and link memories; cursor requests skip the hash. Results come as a one-cycle
// out_valid strobe and cannot be held off; the next start is taken in the cycle
// after the strobe, once busy falls.
module hashed_key_to_slot_map_unit #(
  parameter int CAPACITY = hksm_pkg::CAPACITY_DEF,
  parameter int BUCKETS  = hksm_pkg::BUCKETS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hksm_pkg::hksm_in_t  in_req,
  output logic                out_valid,
  output hksm_pkg::hksm_out_t out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [12:0]         cfg_max_items
);
  import hksm_pkg::*;

  logic [12:0] max_items_r;
  hksm_cmd_t   cmd;
  hksm_sts_t   sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) max_items_r <= 13'd4096;
    else if (cfg_valid && cfg_ready) max_items_r <= cfg_max_items;
  end

  hksm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .sts(sts), .cmd(cmd)
  );

  hksm_datapath #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_req), .max_items(max_items_r),
    .cmd(cmd), .sts(sts), .res(out_res)
  );
endmodule

// ----- rtl/core/hksm_ram.sv -----
// generic single port write, single port read ram with registered read
module hksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/hksm_datapath.sv -----
// hash, chain walk, entry store and cursor datapath
module hksm_datapath #(
  parameter int CAPACITY = hksm_pkg::CAPACITY_DEF,
  parameter int BUCKETS  = hksm_pkg::BUCKETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hksm_pkg::hksm_in_t    req,
  input  logic [12:0]           max_items,
  input  hksm_pkg::hksm_cmd_t   cmd,
  output hksm_pkg::hksm_sts_t   sts,
  output hksm_pkg::hksm_out_t   res
);
  import hksm_pkg::*;

  localparam int CW = $clog2(CAPACITY);
  localparam int BW = $clog2(BUCKETS);
  localparam int NW = CW + 1;

  logic [1:0]    op_r;
  logic [31:0]   key_r;
  logic [31:0]   hmul_r;
  logic [BW-1:0] bucket_r;
  logic [NW-1:0] count_r, cur_pos_r, cur_lim_r;
  logic [CW-1:0] walk_r;
  logic          walk_v_r;
  logic [BW-1:0] sweep_r;
  logic          sweep_done_r;
  hksm_out_t     res_r;

  // bucket head ram holds {valid, slot}; cleared by a pass after reset
  logic          hd_we;
  logic [BW-1:0] hd_wa;
  logic [CW:0]   hd_wd, hd_rd;
  logic          ks_we;
  logic [CW-1:0] ks_ra;
  logic [31:0]   ks_rd;
  logic [CW:0]   cn_rd;
  logic [31:0]   hmix;
  logic [NW-1:0] limit;

  assign hd_we = cmd.do_insert | cmd.clr_sweep;
  assign hd_wa = cmd.clr_sweep ? sweep_r : bucket_r;
  assign hd_wd = cmd.clr_sweep ? '0 : {1'b1, count_r[CW-1:0]};

  hksm_ram #(.WIDTH(CW + 1), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
    .raddr(bucket_r), .rdata(hd_rd)
  );

  assign ks_we = cmd.do_insert;
  assign ks_ra = cmd.key_rd_cur ? cur_pos_r[CW-1:0] : walk_r;

  hksm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(ks_we), .waddr(count_r[CW-1:0]), .wdata(key_r),
    .raddr(ks_ra), .rdata(ks_rd)
  );

  // chain link written with the bucket head that the new entry displaces
  hksm_ram #(.WIDTH(CW + 1), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(ks_we), .waddr(count_r[CW-1:0]), .wdata(hd_rd),
    .raddr(walk_r), .rdata(cn_rd)
  );

  assign hmix  = hmul_r ^ (hmul_r >> 15);
  assign limit = (32'(max_items) > 32'(CAPACITY)) ? NW'(CAPACITY) : NW'(max_items);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      cur_pos_r    <= '0;
      cur_lim_r    <= '0;
      walk_v_r     <= 1'b0;
      sweep_r      <= '0;
      sweep_done_r <= 1'b0;
    end else begin
      if (cmd.clr_sweep) begin
        sweep_r <= sweep_r + 1'b1;
        if (sweep_r == BW'(BUCKETS - 1)) sweep_done_r <= 1'b1;
      end
      if (cmd.head_take) begin
        walk_v_r <= hd_rd[CW];
        walk_r   <= hd_rd[CW-1:0];
      end
      if (cmd.step) begin
        walk_v_r <= cn_rd[CW];
        walk_r   <= cn_rd[CW-1:0];
      end
      if (cmd.do_insert) count_r <= count_r + 1'b1;
      if (cmd.do_cstart) begin
        cur_pos_r <= '0;
        cur_lim_r <= count_r;
      end
      if (cmd.emit && cmd.use_cur) cur_pos_r <= cur_pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      op_r  <= req.operation;
      key_r <= req.key;
    end
    hmul_r <= hash_fold(key_r) * HASH_MULT;
    if (cmd.hash_mix) bucket_r <= hmix[BW-1:0];
    if (cmd.emit) begin
      res_r.status     <= cmd.st;
      res_r.slot       <= cmd.use_walk ? 12'(walk_r) :
                          cmd.use_new  ? 12'(count_r) :
                          cmd.use_cur  ? 12'(cur_pos_r) : '0;
      res_r.key_out    <= cmd.use_cur ? ks_rd : '0;
      res_r.item_count <= 13'(count_r + NW'(cmd.use_new));
    end
  end

  assign sts.op         = op_r;
  assign sts.walk_ok    = walk_v_r && ({1'b0, walk_r} < count_r);
  assign sts.key_hit    = (ks_rd == key_r);
  assign sts.room       = count_r < limit;
  assign sts.cur_ok     = cur_pos_r < cur_lim_r;
  assign sts.sweep_done = sweep_done_r;
  assign res            = res_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(CAPACITY)) else $error("entry count above capacity");
  a_cur_lim: assert property (@(posedge clk) disable iff (!rst_n)
    cur_lim_r <= count_r) else $error("cursor limit above entry count");
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> sts.room) else $error("insert with no room");
  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.do_insert) |-> count_r == $past(count_r) + 1'b1)
    else $error("count did not advance on insert");
endmodule

// ----- rtl/core/hksm_ctrl.sv -----
// controller state machine sequencing hash, chain walk and cursor steps
module hksm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  input  hksm_pkg::hksm_sts_t sts,
  output hksm_pkg::hksm_cmd_t cmd
);
  import hksm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_MIX   = 4'd3;
  localparam logic [3:0] S_HEAD  = 4'd4;
  localparam logic [3:0] S_TAKE  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_CUR   = 4'd8;
  localparam logic [3:0] S_CEMIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_sweep = 1'b1;
        if (sts.sweep_done) begin
          cmd.clr_sweep = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap_req = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        // cursor requests need no hash
        if (sts.op == OP_CSTART) begin
          cmd.do_cstart = 1'b1;
          cmd.emit      = 1'b1;
          cmd.st        = ST_CSTART;
          strobe_nxt    = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.op == OP_CNEXT) begin
          state_nxt = S_CUR;
        end else begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        cmd.hash_mix = 1'b1;
        state_nxt    = S_HEAD;
      end
      S_HEAD: begin
        // bucket head read in flight
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd.head_take = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        if (sts.walk_ok) begin
          state_nxt = S_CMP;
        end else begin
          cmd.emit = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = S_OUT;
          if (sts.op == OP_LOOKUP) begin
            cmd.st = ST_ABSENT;
          end else if (sts.room) begin
            // head ram still shows the old head for the chain link
            cmd.do_insert = 1'b1;
            cmd.use_new   = 1'b1;
            cmd.st        = ST_INSERTED;
          end else begin
            cmd.st = ST_FULL;
          end
        end
      end
      S_CMP: begin
        if (sts.key_hit) begin
          cmd.emit     = 1'b1;
          cmd.use_walk = 1'b1;
          cmd.st       = ST_FOUND;
          strobe_nxt   = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CUR: begin
        if (sts.cur_ok) begin
          cmd.key_rd_cur = 1'b1;
          state_nxt      = S_CEMIT;
        end else begin
          cmd.emit   = 1'b1;
          cmd.st     = ST_CEND;
          strobe_nxt = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_CEMIT: begin
        cmd.emit    = 1'b1;
        cmd.use_cur = 1'b1;
        cmd.st      = ST_CITEM;
        strobe_nxt  = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = strobe_r;

  a_strobe_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("strobe outside result state");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_req |-> state_r == S_IDLE) else $error("request taken while busy");
endmodule

// ----- tb/tb_hashed_key_to_slot_map_unit.sv -----
// testbench for the hashed key to slot map: directed and random insert, lookup and cursor traffic
`timescale 1ns / 1ps

module tb_hashed_key_to_slot_map_unit;
  import hksm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // mirror of the table: key to slot map plus keys in insertion order
  class slot_map_scoreboard;
    int unsigned slot_of[bit [31:0]];
    bit [31:0] key_by_slot[$];
    int unsigned cursor_pos = 0;
    int unsigned cursor_lim = 0;
    int unsigned max_items = 4096;
    hksm_out_t pending[$];
    int errors = 0;

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void note_request(hksm_in_t req);
      hksm_out_t res;
      int unsigned cap;
      int unsigned n;
      res = '0;
      cap = (max_items < CAPACITY_DEF) ? max_items : CAPACITY_DEF;
      n = key_by_slot.size();
      case (req.operation)
        OP_LOOKUP: begin
          if (slot_of.exists(req.key)) begin
            res.status = ST_FOUND;
            res.slot = 12'(slot_of[req.key]);
          end else begin
            res.status = ST_ABSENT;
          end
        end
        OP_INSERT: begin
          if (slot_of.exists(req.key)) begin
            res.status = ST_FOUND;
            res.slot = 12'(slot_of[req.key]);
          end else if (n < cap) begin
            slot_of[req.key] = n;
            key_by_slot.push_back(req.key);
            res.status = ST_INSERTED;
            res.slot = 12'(n);
          end else begin
            res.status = ST_FULL;
          end
        end
        OP_CSTART: begin
          cursor_pos = 0;
          cursor_lim = n;
          res.status = ST_CSTART;
        end
        default: begin
          if (cursor_pos < cursor_lim) begin
            res.status = ST_CITEM;
            res.slot = 12'(cursor_pos);
            res.key_out = key_by_slot[cursor_pos];
            cursor_pos++;
          end else begin
            res.status = ST_CEND;
          end
        end
      endcase
      res.item_count = 13'(key_by_slot.size());
      pending.push_back(res);
    endfunction

    task check_result(hksm_out_t got);
      hksm_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.status), 32'd0);
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.slot !== want.slot) report_mismatch("slot", 32'(got.slot), 32'(want.slot));
        if (got.key_out !== want.key_out) report_mismatch("key_out", got.key_out, want.key_out);
        if (got.item_count !== want.item_count)
          report_mismatch("item_count", 32'(got.item_count), 32'(want.item_count));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  hksm_in_t in_req = '0;
  logic out_valid;
  hksm_out_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_max_items = '0;

  slot_map_scoreboard sb = new();
  int idle_cycles = 0;

  always #2 clk = ~clk;

  hashed_key_to_slot_map_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_max_items(cfg_max_items)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task send_request(logic [1:0] op, logic [31:0] key);
    hksm_in_t req;
    req.operation = op;
    req.key = key;
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  // mostly short gaps, now and then a long one
  task idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) n = 0;
    else if (r < 92) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task write_max(logic [12:0] value);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_items <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.max_items = 32'(value);
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned n;
    n = sb.key_by_slot.size();
    if (n > 0 && $urandom_range(0, 99) < 50) return sb.key_by_slot[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  task random_phase(int count);
    int r;
    int k;
    k = 0;
    while (k < count) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_request(OP_INSERT, pick_key());
      else if (r < 70) send_request(OP_LOOKUP, pick_key());
      else if (r < 80) begin
        // cursor start followed by a run of next requests
        send_request(OP_CSTART, $urandom());
        repeat ($urandom_range(1, 12)) begin
          idle_gap();
          send_request(OP_CNEXT, $urandom());
          k++;
        end
      end else send_request(OP_CNEXT, $urandom());
      k++;
      idle_gap();
    end
  endtask

  initial begin
    int unsigned settings[6];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_max(13'd8191);
    // directed: cursor without start, extremes, duplicates, frozen cursor
    send_request(OP_CNEXT, 32'h0);
    send_request(OP_LOOKUP, 32'h0);
    send_request(OP_INSERT, 32'h0);
    send_request(OP_INSERT, 32'hffffffff);
    send_request(OP_INSERT, 32'h0);
    send_request(OP_LOOKUP, 32'hffffffff);
    send_request(OP_LOOKUP, 32'h12345678);
    send_request(OP_INSERT, 32'h00ff0000);
    send_request(OP_INSERT, 32'h0000ffff);
    send_request(OP_CSTART, 32'h0);
    send_request(OP_CNEXT, 32'h0);
    send_request(OP_INSERT, 32'hff000000);
    send_request(OP_CNEXT, 32'h0);
    send_request(OP_CNEXT, 32'h0);
    send_request(OP_CNEXT, 32'h0);
    send_request(OP_CNEXT, 32'h0);
    send_request(OP_CNEXT, 32'h0);
    write_max(13'd2);
    send_request(OP_INSERT, 32'h55555555);
    send_request(OP_INSERT, 32'hffffffff);
    send_request(OP_LOOKUP, 32'h00ff0000);
    write_max(13'd0);
    send_request(OP_INSERT, 32'haaaaaaaa);
    send_request(OP_INSERT, 32'h0);
    write_max(13'd4096);
    send_request(OP_INSERT, 32'haaaaaaaa);

    settings = '{8191, 40, 0, 4096, 100, 2000};
    foreach (settings[i]) begin
      write_max(13'(settings[i]));
      random_phase(180);
    end
    write_max(13'($urandom_range(0, 8191)));
    random_phase(40);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/hksm_pkg.sv
rtl/core/hksm_ram.sv
rtl/core/hksm_datapath.sv
rtl/core/hksm_ctrl.sv
rtl/core/hashed_key_to_slot_map_unit.sv
tb/tb_hashed_key_to_slot_map_unit.sv
